FILE: rtl/ppm_frame_decoder_unit_assert.svh
// Assertion macros for the PPM frame decoder.
// No dependencies; included by the top level.
`ifndef PPM_FRAME_DECODER_UNIT_ASSERT_SVH
`define PPM_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define PPMFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define PPMFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppmfd_pkg.sv
// Shared types and constants of the PPM frame decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppmfd_pkg;

    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;

    // Request codes
    localparam logic REQ_OVERFLOW = 1'b0;
    localparam logic REQ_EDGE     = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_COUNT_SHIFT     = 3'd0;
    localparam logic [2:0] REG_SYNC_MIN        = 3'd1;
    localparam logic [2:0] REG_PULSE_MIN       = 3'd2;
    localparam logic [2:0] REG_PULSE_MAX       = 3'd3;
    localparam logic [2:0] REG_STABLE_REQUIRED = 3'd4;
    localparam logic [2:0] REG_MIN_CHANNELS    = 3'd5;
    localparam logic [2:0] REG_TIMEOUT_VALUE   = 3'd6;

    // Register reset values
    localparam logic [1:0]  RST_COUNT_SHIFT     = 2'd0;
    localparam logic [15:0] RST_SYNC_MIN        = 16'd2700;
    localparam logic [15:0] RST_PULSE_MIN       = 16'd750;
    localparam logic [15:0] RST_PULSE_MAX       = 16'd2250;
    localparam logic [4:0]  RST_STABLE_REQUIRED = 5'd25;
    localparam logic [3:0]  RST_MIN_CHANNELS    = 4'd4;
    localparam logic [15:0] RST_TIMEOUT_VALUE   = 16'd0;

    // Timer
    localparam logic [16:0] TIMER_PERIOD = 17'h10000;
    localparam logic [15:0] CAPTURE_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  count_shift;
        logic [15:0] sync_min;
        logic [15:0] pulse_min;
        logic [15:0] pulse_max;
        logic [4:0]  stable_required;
        logic [3:0]  min_channels;
        logic [15:0] timeout_value;
    } t_cfg;

    // One operation of the shared adder: a + (inv_b ? ~b : b) + cin
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              inv_b;
        logic              cin;
    } t_alu_req;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              carry;
    } t_alu_rsp;

endpackage

`default_nettype wire

FILE: rtl/ppmfd_alu.sv
// Shared 32-bit add/subtract unit of the PPM frame decoder.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_alu
    import ppmfd_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [DATA_W-1:0] b_eff;
    logic [DATA_W:0]   total;

    assign b_eff = i_req.inv_b ? ~i_req.b : i_req.b;
    assign total = {1'b0, i_req.a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, i_req.cin};

    // carry set on a subtract means no borrow, i.e. a >= b
    assign o_rsp.sum   = total[DATA_W-1:0];
    assign o_rsp.carry = total[DATA_W];

endmodule

`default_nettype wire

FILE: rtl/ppmfd_regs.sv
// APB-style configuration registers of the PPM frame decoder.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_regs
    import ppmfd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[PADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_shift     <= RST_COUNT_SHIFT;
            r_cfg.sync_min        <= RST_SYNC_MIN;
            r_cfg.pulse_min       <= RST_PULSE_MIN;
            r_cfg.pulse_max       <= RST_PULSE_MAX;
            r_cfg.stable_required <= RST_STABLE_REQUIRED;
            r_cfg.min_channels    <= RST_MIN_CHANNELS;
            r_cfg.timeout_value   <= RST_TIMEOUT_VALUE;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_COUNT_SHIFT:     r_cfg.count_shift     <= pwdata[1:0];
                REG_SYNC_MIN:        r_cfg.sync_min        <= pwdata[15:0];
                REG_PULSE_MIN:       r_cfg.pulse_min       <= pwdata[15:0];
                REG_PULSE_MAX:       r_cfg.pulse_max       <= pwdata[15:0];
                REG_STABLE_REQUIRED: r_cfg.stable_required <= pwdata[4:0];
                REG_MIN_CHANNELS:    r_cfg.min_channels    <= pwdata[3:0];
                REG_TIMEOUT_VALUE:   r_cfg.timeout_value   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_COUNT_SHIFT:     prdata = 32'(r_cfg.count_shift);
            REG_SYNC_MIN:        prdata = 32'(r_cfg.sync_min);
            REG_PULSE_MIN:       prdata = 32'(r_cfg.pulse_min);
            REG_PULSE_MAX:       prdata = 32'(r_cfg.pulse_max);
            REG_STABLE_REQUIRED: prdata = 32'(r_cfg.stable_required);
            REG_MIN_CHANNELS:    prdata = 32'(r_cfg.min_channels);
            REG_TIMEOUT_VALUE:   prdata = 32'(r_cfg.timeout_value);
            default:             prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ppm_frame_decoder_unit.sv
// PPM frame decoder: an overflow word passes through the OVF step, an edge word through the LT, BASE,
// NOW, DIFF, DELTA and SYNC steps (then MIN and MAX for a channel pulse); input stall stays high
// meanwhile, as one 32-bit adder is stepped by the sequencer. A sync ending a good frame then issues
// MAX_CHANNELS words, one per cycle while the output is not stalled, before the next word is taken.
// Reset is synchronous, active low: clears time base, tracking and learned channel count and
// loads register defaults; the width store needs no clearing pass.
`default_nettype none
`include "ppm_frame_decoder_unit_assert.svh"

module ppm_frame_decoder_unit
    import ppmfd_pkg::*;
#(
    parameter int MAX_CHANNELS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input words
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic [15:0]        i_capture,
    // output words
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [3:0]         o_channel_index,
    output logic      [15:0]        o_pulse_width,
    output logic      [7:0]         o_frame_number,
    output logic                    o_last,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int SW    = $clog2(MAX_CHANNELS + 1);
    localparam int IW    = $clog2(MAX_CHANNELS);
    localparam int CMP_W = (SW > 5) ? SW : 5;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OVF   = 4'd1;
    localparam logic [3:0] ST_LT    = 4'd2;
    localparam logic [3:0] ST_BASE  = 4'd3;
    localparam logic [3:0] ST_NOW   = 4'd4;
    localparam logic [3:0] ST_DIFF  = 4'd5;
    localparam logic [3:0] ST_DELTA = 4'd6;
    localparam logic [3:0] ST_SYNC  = 4'd7;
    localparam logic [3:0] ST_MIN   = 4'd8;
    localparam logic [3:0] ST_MAX   = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    t_cfg     cfg;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    // control state
    logic [3:0]        r_state, n_state;
    logic [31:0]       r_time_base, n_time_base;
    logic              r_wrapped, n_wrapped;
    logic [31:0]       r_last_time, n_last_time;
    logic [15:0]       r_last_cap, n_last_cap;
    logic [SW-1:0]     r_slot, n_slot;
    logic              r_learned_valid, n_learned_valid;
    logic [SW-1:0]     r_learned, n_learned;
    logic              r_prev_valid, n_prev_valid;
    logic [SW-1:0]     r_prev, n_prev;
    logic [4:0]        r_stable, n_stable;
    logic              r_tracking, n_tracking;
    logic [7:0]        r_frame, n_frame;
    logic [IW-1:0]     r_k, n_k;
    logic              r_out_valid, n_out_valid;

    // working values
    logic [15:0]       r_cap, n_cap;
    logic [31:0]       r_acc, n_acc;
    logic [31:0]       r_now, n_now;
    logic              r_lt, n_lt;
    logic              r_gt, n_gt;
    logic              r_above, n_above;
    logic [15:0]       r_pending [MAX_CHANNELS];
    logic              pend_we;

    // output payload
    logic [3:0]        r_out_index, n_out_index;
    logic [15:0]       r_out_width, n_out_width;
    logic [7:0]        r_out_frame, n_out_frame;
    logic              r_out_last, n_out_last;

    logic              in_take;
    logic              out_take;
    logic              out_load;
    logic              stable_hit;
    logic              emit_go;
    logic [31:0]       period;

    ppmfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppmfd_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_in_stall      = (r_state != ST_IDLE);
    assign in_take         = i_in_valid && !o_in_stall;
    assign out_take        = r_out_valid && !i_out_stall;
    assign out_load        = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    assign period          = 32'(TIMER_PERIOD >> cfg.count_shift);

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_pulse_width   = r_out_width;
    assign o_frame_number  = r_out_frame;
    assign o_last          = r_out_last;

    assign stable_hit = r_prev_valid && (r_slot == r_prev)
                     && (CMP_W'(r_slot) >= CMP_W'(cfg.min_channels))
                     && (CMP_W'(r_slot) <= CMP_W'(MAX_CHANNELS));

    // operand selection for the shared adder
    always_comb begin
        alu_req = '0;
        unique case (r_state)
            ST_OVF: begin
                alu_req.a   = r_time_base;
                alu_req.b   = 32'(r_cap);
                alu_req.cin = 1'b1;
            end
            ST_LT: begin
                alu_req.a     = 32'(r_cap);
                alu_req.b     = 32'(r_last_cap);
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
            end
            ST_BASE: begin
                alu_req.a = r_time_base;
                alu_req.b = 32'(r_cap);
            end
            ST_NOW: begin
                alu_req.a = r_acc;
                alu_req.b = (r_lt && r_wrapped) ? 32'(TIMER_PERIOD) : 32'd0;
            end
            ST_DIFF: begin
                alu_req.a     = r_now;
                alu_req.b     = r_last_time;
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
            end
            ST_DELTA: begin
                // later edge: drop a full period if one wrapped; earlier edge: add one
                alu_req.a     = r_acc;
                alu_req.b     = (r_gt && !r_wrapped) ? 32'd0 : period;
                alu_req.inv_b = r_gt && r_wrapped;
                alu_req.cin   = r_gt && r_wrapped;
            end
            ST_SYNC: begin
                alu_req.a     = 32'(cfg.sync_min);
                alu_req.b     = r_acc;
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
            end
            ST_MIN: begin
                alu_req.a     = 32'(cfg.pulse_min);
                alu_req.b     = r_acc;
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
            end
            ST_MAX: begin
                alu_req.a     = r_acc;
                alu_req.b     = 32'(cfg.pulse_max);
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state         = r_state;
        n_time_base     = r_time_base;
        n_wrapped       = r_wrapped;
        n_last_time     = r_last_time;
        n_last_cap      = r_last_cap;
        n_slot          = r_slot;
        n_learned_valid = r_learned_valid;
        n_learned       = r_learned;
        n_prev_valid    = r_prev_valid;
        n_prev          = r_prev;
        n_stable        = r_stable;
        n_tracking      = r_tracking;
        n_frame         = r_frame;
        n_k             = r_k;
        n_out_valid     = r_out_valid && !out_take;
        n_cap           = r_cap;
        n_acc           = r_acc;
        n_now           = r_now;
        n_lt            = r_lt;
        n_gt            = r_gt;
        n_above         = r_above;
        n_out_index     = r_out_index;
        n_out_width     = r_out_width;
        n_out_frame     = r_out_frame;
        n_out_last      = r_out_last;
        pend_we         = 1'b0;
        emit_go         = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_cap   = i_capture;
                    n_state = (i_req_type == REQ_EDGE) ? ST_LT : ST_OVF;
                end
            end
            ST_OVF: begin
                n_time_base = alu_rsp.sum;
                if (r_cap == CAPTURE_MAX) begin
                    n_wrapped = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_LT: begin
                n_lt    = !alu_rsp.carry;
                n_state = ST_BASE;
            end
            ST_BASE: begin
                n_acc   = alu_rsp.sum;
                n_state = ST_NOW;
            end
            ST_NOW: begin
                n_now   = alu_rsp.sum >> cfg.count_shift;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_acc   = alu_rsp.sum;
                n_gt    = alu_rsp.carry && (alu_rsp.sum != 32'd0);
                n_state = ST_DELTA;
            end
            ST_DELTA: begin
                n_acc       = alu_rsp.sum;
                n_wrapped   = 1'b0;
                n_last_time = r_now;
                n_last_cap  = r_cap;
                n_state     = ST_SYNC;
            end
            ST_SYNC: begin
                if (!alu_rsp.carry) begin
                    // frame end: update stability, then judge the frame just closed
                    if (stable_hit) begin
                        if (r_stable < cfg.stable_required) begin
                            n_stable = r_stable + 5'd1;
                        end else begin
                            n_learned_valid = 1'b1;
                            n_learned       = r_slot;
                        end
                    end else begin
                        n_stable = 5'd0;
                    end
                    emit_go      = n_learned_valid && (r_slot == n_learned) && r_tracking;
                    n_tracking   = 1'b1;
                    n_prev_valid = 1'b1;
                    n_prev       = r_slot;
                    n_slot       = '0;
                    if (emit_go) begin
                        n_frame = r_frame + 8'd1;
                        n_k     = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (r_tracking) begin
                    n_state = ST_MIN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MIN: begin
                n_above = !alu_rsp.carry;
                n_state = ST_MAX;
            end
            ST_MAX: begin
                if (r_above && !alu_rsp.carry && (CMP_W'(r_slot) < CMP_W'(MAX_CHANNELS))) begin
                    pend_we = 1'b1;
                    n_slot  = r_slot + SW'(1);
                end else begin
                    n_tracking = 1'b0;
                end
                n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_index = 4'(r_k);
                    n_out_width = (SW'(r_k) < r_learned) ? r_pending[r_k] : cfg.timeout_value;
                    n_out_frame = r_frame;
                    n_out_last  = (r_k == IW'(MAX_CHANNELS - 1));
                    if (r_k == IW'(MAX_CHANNELS - 1)) begin
                        n_k     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_time_base     <= '0;
            r_wrapped       <= 1'b0;
            r_last_time     <= '0;
            r_last_cap      <= '0;
            r_slot          <= '0;
            r_learned_valid <= 1'b0;
            r_learned       <= '0;
            r_prev_valid    <= 1'b0;
            r_prev          <= '0;
            r_stable        <= '0;
            r_tracking      <= 1'b0;
            r_frame         <= '0;
            r_k             <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_time_base     <= n_time_base;
            r_wrapped       <= n_wrapped;
            r_last_time     <= n_last_time;
            r_last_cap      <= n_last_cap;
            r_slot          <= n_slot;
            r_learned_valid <= n_learned_valid;
            r_learned       <= n_learned;
            r_prev_valid    <= n_prev_valid;
            r_prev          <= n_prev;
            r_stable        <= n_stable;
            r_tracking      <= n_tracking;
            r_frame         <= n_frame;
            r_k             <= n_k;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap       <= n_cap;
        r_acc       <= n_acc;
        r_now       <= n_now;
        r_lt        <= n_lt;
        r_gt        <= n_gt;
        r_above     <= n_above;
        r_out_index <= n_out_index;
        r_out_width <= n_out_width;
        r_out_frame <= n_out_frame;
        r_out_last  <= n_out_last;
    end

    // width store: a channel slot is written once per accepted pulse
    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pending[r_slot[IW-1:0]] <= r_acc[15:0];
        end
    end

    `PPMFD_ASSERT_NEXT(a_ovf_step, i_clk, i_rst_n, in_take && (i_req_type == REQ_OVERFLOW), r_state == ST_OVF, "overflow word did not enter the time base step")
    `PPMFD_ASSERT_NOW(a_emit_learned, i_clk, i_rst_n, r_state == ST_EMIT, r_learned_valid, "frame issued without a learned channel count")
    `PPMFD_ASSERT_NOW(a_slot_bound, i_clk, i_rst_n, 1'b1, CMP_W'(r_slot) <= CMP_W'(MAX_CHANNELS), "slot count beyond channel limit")
    `PPMFD_ASSERT_NOW(a_last_slot, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_index == 4'(MAX_CHANNELS - 1), "last flag on a slot other than the final one")

endmodule

`default_nettype wire

FILE: bench/ppm_frame_decoder_unit_tb.sv
// Self-checking bench for ppm_frame_decoder_unit: drives timer words, predicts the slot words.
// Depends on ppmfd_pkg for request codes, register indexes, reset values and t_cfg.
`default_nettype none

module ppm_frame_decoder_unit_tb;
    import ppmfd_pkg::*;

    localparam int NUM_SLOTS   = 12;
    localparam int IDLE_GUARD  = 20;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_MAX  = 20000;

    typedef struct packed {
        logic [3:0]  chan;
        logic [15:0] width;
        logic [7:0]  frame;
        logic        last;
    } slot_word_t;

    // Tracks the decoder state and queues the slot words each accepted word should produce
    class frame_slot_tracker;
        logic [1:0]  cfg_shift;
        logic [15:0] cfg_sync_min;
        logic [15:0] cfg_pulse_min;
        logic [15:0] cfg_pulse_max;
        logic [4:0]  cfg_stable_req;
        logic [3:0]  cfg_min_chan;
        logic [15:0] cfg_timeout;

        bit [31:0]   time_base;
        bit          wrapped;
        bit [31:0]   last_time;
        bit [15:0]   last_cap;
        int          slot_cnt;
        bit          learned_ok;
        int          learned_cnt;
        bit          prev_ok;
        int          prev_cnt;
        int          stable_cnt;
        bit          tracking;
        bit [7:0]    frame_cnt;
        bit [15:0]   widths [NUM_SLOTS];

        slot_word_t  expected_slots [$];
        int          fail_count;
        int          shown;

        function new();
            cfg_shift      = RST_COUNT_SHIFT;
            cfg_sync_min   = RST_SYNC_MIN;
            cfg_pulse_min  = RST_PULSE_MIN;
            cfg_pulse_max  = RST_PULSE_MAX;
            cfg_stable_req = RST_STABLE_REQUIRED;
            cfg_min_chan   = RST_MIN_CHANNELS;
            cfg_timeout    = RST_TIMEOUT_VALUE;
            time_base      = '0;
            wrapped        = 1'b0;
            last_time      = '0;
            last_cap       = '0;
            slot_cnt       = 0;
            learned_ok     = 1'b0;
            learned_cnt    = 0;
            prev_ok        = 1'b0;
            prev_cnt       = 0;
            stable_cnt     = 0;
            tracking       = 1'b0;
            frame_cnt      = '0;
            foreach (widths[k]) widths[k] = '0;
            fail_count     = 0;
            shown          = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_COUNT_SHIFT:     cfg_shift      = val[1:0];
                REG_SYNC_MIN:        cfg_sync_min   = val[15:0];
                REG_PULSE_MIN:       cfg_pulse_min  = val[15:0];
                REG_PULSE_MAX:       cfg_pulse_max  = val[15:0];
                REG_STABLE_REQUIRED: cfg_stable_req = val[4:0];
                REG_MIN_CHANNELS:    cfg_min_chan   = val[3:0];
                REG_TIMEOUT_VALUE:   cfg_timeout    = val[15:0];
                default: ;
            endcase
        endfunction

        function int pending_words();
            return expected_slots.size();
        endfunction

        function void note_word(logic rt, logic [15:0] cap);
            bit [31:0] now;
            bit [31:0] span;
            bit [31:0] delta;
            slot_word_t w;
            if (rt == REQ_OVERFLOW) begin
                time_base = time_base + {16'h0, cap} + 32'd1;
                if (cap == CAPTURE_MAX)
                    wrapped = 1'b1;
            end else begin
                now = time_base + {16'h0, cap};
                if (cap < last_cap && wrapped)
                    now = now + 32'h10000;
                now  = now >> cfg_shift;
                span = 32'h10000 >> cfg_shift;
                if (now > last_time)
                    delta = now - (last_time + (wrapped ? span : 32'd0));
                else
                    delta = span + now - last_time;
                wrapped   = 1'b0;
                last_time = now;
                last_cap  = cap;

                if (delta > {16'h0, cfg_sync_min}) begin
                    if (prev_ok && slot_cnt == prev_cnt && slot_cnt >= cfg_min_chan &&
                        slot_cnt <= NUM_SLOTS) begin
                        if (stable_cnt < cfg_stable_req) begin
                            stable_cnt++;
                        end else begin
                            learned_ok  = 1'b1;
                            learned_cnt = slot_cnt;
                        end
                    end else begin
                        stable_cnt = 0;
                    end
                    // a complete, tracked frame of the learned length: queue every slot
                    if (learned_ok && slot_cnt == learned_cnt && tracking) begin
                        frame_cnt++;
                        for (int k = 0; k < NUM_SLOTS; k++) begin
                            w.chan  = 4'(k);
                            w.width = (k < learned_cnt) ? widths[k] : cfg_timeout;
                            w.frame = frame_cnt;
                            w.last  = (k == NUM_SLOTS - 1);
                            expected_slots.push_back(w);
                        end
                    end
                    tracking = 1'b1;
                    prev_ok  = 1'b1;
                    prev_cnt = slot_cnt;
                    slot_cnt = 0;
                end else if (tracking) begin
                    if (delta > {16'h0, cfg_pulse_min} && delta < {16'h0, cfg_pulse_max} &&
                        slot_cnt < NUM_SLOTS) begin
                        widths[slot_cnt] = delta[15:0];
                        slot_cnt++;
                    end else begin
                        tracking = 1'b0;
                        foreach (widths[k]) widths[k] = cfg_timeout;
                    end
                end
            end
        endfunction

        function void check_word(slot_word_t got);
            slot_word_t want;
            if (expected_slots.size() == 0) begin
                fail_count++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected slot word: chan %0d width %0d frame %0d last %0b",
                             got.chan, got.width, got.frame, got.last);
                end
            end else begin
                want = expected_slots.pop_front();
                if (got.chan !== want.chan || got.width !== want.width ||
                    got.frame !== want.frame || got.last !== want.last) begin
                    fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("slot word differs: expected chan %0d width %0d frame %0d last %0b, got chan %0d width %0d frame %0d last %0b",
                                 want.chan, want.width, want.frame, want.last,
                                 got.chan, got.width, got.frame, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [15:0] i_capture;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_channel_index;
    logic [15:0] o_pulse_width;
    logic [7:0]  o_frame_number;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_slot_tracker sb;
    t_cfg              cur_cfg;
    bit [15:0]         tmr_now;
    bit                calm;
    bit                hold_long;

    ppm_frame_decoder_unit #(
        .MAX_CHANNELS(NUM_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_capture      (i_capture),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel_index(o_channel_index),
        .o_pulse_width  (o_pulse_width),
        .o_frame_number (o_frame_number),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("ppm_frame_decoder_unit: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word({o_channel_index, o_pulse_width, o_frame_number, o_last});
    end

    // Output side: random stall bursts, free stretches, and one long hold on request
    initial begin
        int hold_cycles;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_long) begin
                i_out_stall <= 1'b1;
                hold_cycles = 0;
                while (hold_cycles < LONG_HOLD) begin
                    @(negedge i_clk);
                    hold_cycles++;
                end
                hold_long = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
        end
    end

    task automatic send_word(input logic rt, input logic [15:0] cap);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_capture  <= cap;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(rt, cap);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c);
        apb_write(REG_COUNT_SHIFT,     32'(c.count_shift));
        apb_write(REG_SYNC_MIN,        32'(c.sync_min));
        apb_write(REG_PULSE_MIN,       32'(c.pulse_min));
        apb_write(REG_PULSE_MAX,       32'(c.pulse_max));
        apb_write(REG_STABLE_REQUIRED, 32'(c.stable_required));
        apb_write(REG_MIN_CHANNELS,    32'(c.min_channels));
        apb_write(REG_TIMEOUT_VALUE,   32'(c.timeout_value));
        cur_cfg = c;
    endtask

    // Drop valid, wait for every queued slot word, then give the block time to go idle
    task automatic settle();
        int waited;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_words() != 0 && waited < SETTLE_MAX) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (IDLE_GUARD) @(negedge i_clk);
    endtask

    // Advance the timer by d scaled ticks and capture an edge, wrapping through an overflow
    task automatic step_capture(input int unsigned d);
        int unsigned raw;
        int unsigned pos;
        raw = (d << cur_cfg.count_shift) + $urandom_range(0, (1 << cur_cfg.count_shift) - 1);
        if (raw > 32'hFFFF)
            raw = 32'hFFFF;
        pos = tmr_now + raw;
        if (pos > 32'hFFFF) begin
            send_word(REQ_OVERFLOW, CAPTURE_MAX);
            pos = pos - 32'h10000;
        end
        send_word(REQ_EDGE, pos[15:0]);
        tmr_now = pos[15:0];
    endtask

    task automatic sync_gap();
        int unsigned top;
        int unsigned lo;
        int unsigned d;
        top = 32'hFFFF >> cur_cfg.count_shift;
        lo  = cur_cfg.sync_min + 2;
        if (lo >= top)
            d = top;
        else
            d = lo + $urandom_range(0, (top - lo > 300) ? 300 : top - lo);
        step_capture(d);
    endtask

    task automatic noise_word();
        logic [15:0] cap;
        logic        rt;
        cap = 16'($urandom());
        rt  = $urandom_range(0, 1) ? REQ_EDGE : REQ_OVERFLOW;
        send_word(rt, cap);
        if (rt == REQ_EDGE)
            tmr_now = cap;
    endtask

    task automatic send_frame(input int n, input bit spoil);
        int bad_at;
        int unsigned d;
        bad_at = spoil ? $urandom_range(0, n - 1) : -1;
        for (int k = 0; k < n; k++) begin
            if (k == bad_at) begin
                if ($urandom_range(0, 1))
                    d = $urandom_range(0, cur_cfg.pulse_min);
                else
                    d = $urandom_range(cur_cfg.pulse_max, cur_cfg.sync_min);
            end else begin
                d = $urandom_range(cur_cfg.pulse_min + 1, cur_cfg.pulse_max - 2);
            end
            step_capture(d);
        end
        sync_gap();
    endtask

    task automatic run_frames(input int frames, input int n, input bit messy);
        int r;
        for (int f = 0; f < frames; f++) begin
            r = messy ? $urandom_range(0, 99) : 99;
            if (r < 8)
                send_frame(n, 1'b1);
            else if (r < 14)
                send_frame($urandom_range(1, NUM_SLOTS + 1), 1'b0);
            else if (r < 20) begin
                noise_word();
                send_frame(n, 1'b0);
            end else
                send_frame(n, 1'b0);
        end
    endtask

    function automatic t_cfg gen_cfg(input int n);
        t_cfg c;
        c.count_shift     = 2'($urandom_range(0, 3));
        c.pulse_min       = 16'($urandom_range(100, 1000));
        c.pulse_max       = c.pulse_min + 16'($urandom_range(200, 1500));
        c.sync_min        = c.pulse_max + 16'($urandom_range(50, 2500));
        c.stable_required = 5'($urandom_range(0, 3));
        c.min_channels    = 4'($urandom_range(1, n));
        c.timeout_value   = 16'($urandom());
        return c;
    endfunction

    initial begin
        t_cfg c;
        int   n;
        sb         = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_OVERFLOW;
        i_capture  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        calm       = 1'b0;
        hold_long  = 1'b0;
        tmr_now    = '0;
        cur_cfg    = '{RST_COUNT_SHIFT, RST_SYNC_MIN, RST_PULSE_MIN, RST_PULSE_MAX,
                       RST_STABLE_REQUIRED, RST_MIN_CHANNELS, RST_TIMEOUT_VALUE};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: capture extremes, zero interval, wrap with a lower capture
        send_word(REQ_OVERFLOW, 16'h0000);
        send_word(REQ_OVERFLOW, CAPTURE_MAX);
        send_word(REQ_EDGE, CAPTURE_MAX);
        send_word(REQ_EDGE, CAPTURE_MAX);
        send_word(REQ_EDGE, 16'h0000);
        send_word(REQ_EDGE, 16'hC000);
        send_word(REQ_OVERFLOW, CAPTURE_MAX);
        send_word(REQ_EDGE, 16'h4000);
        tmr_now = 16'h4000;
        send_frame(4, 1'b0);
        send_frame(4, 1'b1);
        settle();

        // Every edge a sync, zero channels learned: frames of timeout slots only
        apply_cfg('{2'd0, 16'd0, 16'd750, 16'd2250, 5'd0, 4'd0, 16'hFFFF});
        repeat (5) step_capture($urandom_range(1, 3000));
        settle();

        // Random settings, mixed frame lengths, broken frames and stray words
        repeat (2) begin
            n = $urandom_range(1, NUM_SLOTS);
            apply_cfg(gen_cfg(n));
            sync_gap();
            run_frames(6, n, 1'b1);
            settle();
        end

        // Full frames at the coarsest prescale; long output hold, then a slot overrun
        c = gen_cfg(NUM_SLOTS);
        c.count_shift     = 2'd3;
        c.stable_required = 5'd1;
        c.min_channels    = 4'(NUM_SLOTS);
        apply_cfg(c);
        sync_gap();
        run_frames(3, NUM_SLOTS, 1'b0);
        hold_long = 1'b1;
        send_frame(NUM_SLOTS + 1, 1'b0);
        run_frames(1, NUM_SLOTS, 1'b0);
        settle();

        // Widest pulse window with sync just below the full period
        apply_cfg('{2'd0, 16'd65533, 16'd0, 16'hFFFF, 5'd2, 4'd1, 16'd0});
        sync_gap();
        run_frames(6, $urandom_range(1, 3), 1'b0);
        settle();

        // Longest stability requirement on one-channel frames
        c = '{2'd2, 16'd3000, 16'd500, 16'd2000, 5'd31, 4'd1, 16'($urandom())};
        apply_cfg(c);
        sync_gap();
        run_frames(36, 1, 1'b0);
        settle();

        // No sync reachable and no pulse in range: stray words only
        c = '{2'($urandom_range(0, 3)), 16'hFFFF, 16'hFFFF, 16'd0, 5'd0, 4'(NUM_SLOTS),
              16'($urandom())};
        apply_cfg(c);
        repeat (20) noise_word();
        settle();

        // Closing stretch without idling on either side
        n = $urandom_range(1, NUM_SLOTS);
        apply_cfg(gen_cfg(n));
        calm = 1'b1;
        sync_gap();
        run_frames(6, n, 1'b1);
        settle();

        if (sb.pending_words() != 0) begin
            $display("%0d slot words never arrived", sb.pending_words());
            sb.fail_count += sb.pending_words();
        end
        if (sb.fail_count == 0)
            $display("ppm_frame_decoder_unit: match");
        else
            $display("ppm_frame_decoder_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
